>>> rtl/core/efm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efm_pkg
// shared widths and stage payload types for the extended float multiply
// ----------------------------------------------------------------------------
package efm_pkg;
    localparam int unsigned MANT_W = 64;
    localparam int unsigned EXP_W  = 16;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned ESUM_W = 18;
    localparam int unsigned LZ_W   = 7;

    typedef struct packed {
        logic              sign;
        logic [EXP_W-1:0]  exp;
        logic [MANT_W-1:0] mant;
        logic              overflow;
        logic              underflow;
    } t_result;

    typedef struct packed {
        logic                     sign;
        logic signed [ESUM_W-1:0] esum;
        logic                     ovf;
        logic                     unf;
    } t_exp_info;
endpackage
`default_nettype wire

>>> rtl/core/efm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efm_in_if / efm_out_if
// valid/ready channels for operand pairs and products
// ----------------------------------------------------------------------------
interface efm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        sign_a;
    logic signed [15:0]          exp_a;
    logic [63:0]                 mant_a;
    logic                        sign_b;
    logic signed [15:0]          exp_b;
    logic [63:0]                 mant_b;
    modport source (output valid, sign_a, exp_a, mant_a, sign_b, exp_b, mant_b,
                    input ready);
    modport sink   (input valid, sign_a, exp_a, mant_a, sign_b, exp_b, mant_b,
                    output ready);
endinterface

interface efm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        sign_out;
    logic signed [15:0]          exp_out;
    logic [63:0]                 mant_out;
    logic                        overflow;
    logic                        underflow;
    modport source (output valid, sign_out, exp_out, mant_out, overflow, underflow,
                    input ready);
    modport sink   (input valid, sign_out, exp_out, mant_out, overflow, underflow,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/extended_float_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// extended_float_multiply
// sign / exponent / 64-bit mantissa multiply with truncation and normalize
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output is not stalled
// the whole pipe advances together and freezes when the output is stalled
// reset clears all stage valid bits; payload registers are not reset
module extended_float_multiply #(
    parameter int EXP_MAX = 16383,
    parameter int EXP_MIN = -16382
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    efm_in_if.sink    i_in,
    efm_out_if.source o_out
);
    localparam int unsigned DEPTH = 5;

    logic [DEPTH-1:0] r_vld;
    logic             adv;

    // pipe moves whenever the output slot is empty or being taken
    assign adv        = !r_vld[DEPTH-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[DEPTH-2:0], i_in.valid};
    end

    // exponent path, computed at entry and delayed to match the multiplier
    efm_pkg::t_exp_info n_info;
    efm_pkg::t_exp_info r_info [3];
    logic signed [17:0] n_sum;

    always_comb begin
        n_sum = 18'(i_in.exp_a) + 18'(i_in.exp_b) - 18'sd1;
        n_info.sign = i_in.sign_a ^ i_in.sign_b;
        n_info.esum = n_sum;
        n_info.ovf  = (n_sum >= 18'(EXP_MAX));
        n_info.unf  = !(n_sum >= 18'(EXP_MAX)) && (n_sum < 18'(EXP_MIN));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_info[0] <= n_info;
            r_info[1] <= r_info[0];
            r_info[2] <= r_info[1];
        end
    end

    logic [63:0]       hi;
    efm_pkg::t_result  res;

    efm_mul u_mul (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (i_in.mant_a),
        .i_b   (i_in.mant_b),
        .o_hi  (hi)
    );

    efm_norm #(
        .EXP_MAX (EXP_MAX),
        .EXP_MIN (EXP_MIN)
    ) u_norm (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_mant (hi),
        .i_info (r_info[2]),
        .o_res  (res)
    );

    assign o_out.valid     = r_vld[DEPTH-1];
    assign o_out.sign_out  = res.sign;
    assign o_out.exp_out   = res.exp;
    assign o_out.mant_out  = res.mant;
    assign o_out.overflow  = res.overflow;
    assign o_out.underflow = res.underflow;
endmodule
`default_nettype wire

>>> rtl/core/efm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efm_mul
// three-stage 64x64 upper-half multiplier built from 32x32 partial products
// ----------------------------------------------------------------------------
module efm_mul (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_hi
);
    logic [63:0] r_ll, r_lh, r_hl, r_hh;
    logic [33:0] r_mid;
    logic [63:0] r_top;
    logic [63:0] r_hi;

    // stage 1: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0]  * i_b[31:0];
            r_lh <= i_a[31:0]  * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
            r_hh <= i_a[63:32] * i_b[63:32];
        end
    end

    // stage 2: middle column and upper sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= {2'b00, r_ll[63:32]} + {2'b00, r_lh[31:0]} + {2'b00, r_hl[31:0]};
            r_top <= r_hh + {32'd0, r_lh[63:32]} + {32'd0, r_hl[63:32]};
        end
    end

    // stage 3: fold carry
    always_ff @(posedge i_clk) begin
        if (i_en) r_hi <= r_top + {62'd0, r_mid[33:32]};
    end

    assign o_hi = r_hi;
endmodule
`default_nettype wire

>>> rtl/core/efm_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efm_norm
// two-stage leading-zero count and normalizing shift with exponent fix
// ----------------------------------------------------------------------------
module efm_norm #(
    parameter int EXP_MAX = 16383,
    parameter int EXP_MIN = -16382
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [63:0]         i_mant,
    input  wire efm_pkg::t_exp_info  i_info,
    output efm_pkg::t_result         o_res
);
    logic [63:0]             r_mant;
    efm_pkg::t_exp_info      r_info;
    logic [6:0]              r_lz;
    logic [5:0]              n_lz;
    logic                    n_zero;
    efm_pkg::t_result        r_res, n_res;
    logic signed [17:0]      n_e;

    // priority encoder for the top set bit
    always_comb begin
        n_lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (i_mant[i]) n_lz = 6'(63 - i);
        end
        n_zero = (i_mant == 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant <= i_mant;
            r_info <= i_info;
            r_lz   <= {n_zero, n_lz};
        end
    end

    always_comb begin
        n_e = r_info.esum - 18'(r_lz[5:0]);
        n_res.sign      = r_info.sign;
        n_res.overflow  = r_info.ovf;
        n_res.underflow = r_info.unf;
        priority if (r_info.ovf) begin
            n_res.exp  = 16'(EXP_MAX);
            n_res.mant = 64'd0;
        end else if (r_info.unf) begin
            n_res.exp  = 16'(EXP_MIN);
            n_res.mant = 64'd0;
        end else if (r_lz[6]) begin
            n_res.exp  = 16'd0;
            n_res.mant = 64'd0;
        end else begin
            n_res.exp  = n_e[15:0];
            n_res.mant = r_mant << r_lz[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_res <= n_res;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

>>> tb/tb_extended_float_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_extended_float_multiply
// drives operand pairs through the multiplier under random idling on both
// channels and checks each product against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_extended_float_multiply;
    localparam int EXP_MAX_V = 16383;
    localparam int EXP_MIN_V = -16382;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    efm_in_if  in_ch ();
    efm_out_if out_ch ();

    extended_float_multiply dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // expected products, oldest first
    efm_pkg::t_result product_q[$];
    int          mismatches = 0;
    int unsigned cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // predictor: sign xor, exponent sum with saturation, truncated normalize
    function automatic efm_pkg::t_result predict_product(logic sa, logic signed [15:0] ea,
                                                logic [63:0] ma, logic sb,
                                                logic signed [15:0] eb, logic [63:0] mb);
        efm_pkg::t_result r;
        int e;
        logic [127:0] full;
        logic [63:0] m;
        r = '0;
        r.sign = sa ^ sb;
        e = int'(ea) + int'(eb) - 1;
        if (e >= EXP_MAX_V) begin
            r.exp = EXP_MAX_V[15:0];
            r.overflow = 1'b1;
        end else if (e < EXP_MIN_V) begin
            r.exp = EXP_MIN_V[15:0];
            r.underflow = 1'b1;
        end else begin
            full = {64'd0, ma} * {64'd0, mb};
            m = full[127:64];
            if (m == 64'd0) begin
                r.exp = '0;
            end else begin
                while (!m[63]) begin
                    m = m << 1;
                    e = e - 1;
                end
                r.exp = e[15:0];
                r.mant = m;
            end
        end
        return r;
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sign_a = 1'b0;
        in_ch.exp_a = '0;
        in_ch.mant_a = '0;
        in_ch.sign_b = 1'b0;
        in_ch.exp_b = '0;
        in_ch.mant_b = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stall decided at each falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // product checker, sampled at the rising edge
    always @(posedge i_clk) begin
        efm_pkg::t_result got;
        efm_pkg::t_result want;
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.sign_out, out_ch.exp_out, out_ch.mant_out,
                    out_ch.overflow, out_ch.underflow};
            if (product_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected product %h", got);
            end else begin
                want = product_q.pop_front();
                if (got.sign !== want.sign || got.exp !== want.exp ||
                    got.mant !== want.mant || got.overflow !== want.overflow ||
                    got.underflow !== want.underflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"product: expected s%0b e%h m%h o%0b u%0b, ",
                                  "got s%0b e%h m%h o%0b u%0b"},
                                 want.sign, want.exp, want.mant, want.overflow,
                                 want.underflow, got.sign, got.exp, got.mant,
                                 got.overflow, got.underflow);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("extended_float_multiply: mismatch");
            $finish;
        end
    end

    // send one operand pair, optionally after a random gap
    task automatic send_pair(logic sa, logic signed [15:0] ea, logic [63:0] ma,
                             logic sb, logic signed [15:0] eb, logic [63:0] mb);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sign_a <= sa;
        in_ch.exp_a  <= ea;
        in_ch.mant_a <= ma;
        in_ch.sign_b <= sb;
        in_ch.exp_b  <= eb;
        in_ch.mant_b <= mb;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        product_q.push_back(predict_product(sa, ea, ma, sb, eb, mb));
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_mant();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(5))
            0: m = m >> $urandom_range(63);   // unnormalized
            1: m = '0;
            default: m[63] = 1'b1;           // normalized
        endcase
        return m;
    endfunction

    // exponents mostly in range, some near the saturation edges
    function automatic logic signed [15:0] rand_exp();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(8300, 8100));
            2: return -16'($urandom_range(8300, 8100));
            default: return 16'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // extremes of each field, flag boundaries, zero and unnormalized products
    task automatic test_directed();
        send_pair(1'b0, 16'sd0, '1, 1'b0, 16'sd0, '1);
        send_pair(1'b1, 16'sd1, 64'h8000_0000_0000_0000,
                  1'b0, 16'sd1, 64'h8000_0000_0000_0000);
        send_pair(1'b0, 16'sd32767, '1, 1'b1, 16'sd32767, '1);
        send_pair(1'b1, -16'sd32768, '1, 1'b1, -16'sd32768, '1);
        send_pair(1'b0, 16'sd32767, '1, 1'b0, -16'sd32768, '1);
        // exponent sum right at the overflow edge and just below it
        send_pair(1'b0, 16'sd8192, '1, 1'b0, 16'sd8192, '1);
        send_pair(1'b0, 16'sd8191, '1, 1'b1, 16'sd8192, '1);
        // right at the underflow edge and just past it
        send_pair(1'b1, -16'sd8191, '1, 1'b0, -16'sd8190, '1);
        send_pair(1'b0, -16'sd8191, '1, 1'b0, -16'sd8191, '1);
        // zero products
        send_pair(1'b0, 16'sd5, '0, 1'b0, 16'sd7, '1);
        send_pair(1'b1, 16'sd5, 64'd1, 1'b0, 16'sd7, 64'd1);
        // unnormalized operands with long normalize shifts
        send_pair(1'b0, 16'sd3, 64'h0000_0001_0000_0000,
                  1'b1, 16'sd2, 64'h0000_0001_0000_0000);
        send_pair(1'b0, 16'sd0, 64'h2, 1'b0, 16'sd0, '1);
        // normalize drives the exponent past the minimum with no check
        send_pair(1'b1, -16'sd8191, 64'h2, 1'b1, -16'sd8190, '1);
        send_pair(1'b0, 16'sd100, 64'h5555_5555_5555_5555,
                  1'b1, -16'sd50, 64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_pair(1'($urandom_range(1)), rand_exp(), rand_mant(),
                      1'($urandom_range(1)), rand_exp(), rand_mant());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 8;
        recv_idle_pct = 62;
        test_directed();
        test_random(200);
        send_idle_pct = 62;
        recv_idle_pct = 8;
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(230);
        in_ch.valid <= 1'b0;

        // drain, then let the 5-stage pipe settle
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("extended_float_multiply: match");
        else
            $display("extended_float_multiply: mismatch");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/efm_pkg.sv
rtl/core/efm_if.sv
rtl/core/efm_mul.sv
rtl/core/efm_norm.sv
rtl/core/extended_float_multiply.sv
tb/tb_extended_float_multiply.sv
